/* sv/lrupr_pkg.sv */
// Shared types and constants for the LRU page replacement block.
// No dependencies; used by lrupr_cell and lru_page_replacement.
package lrupr_pkg;

	// Configuration register: frames in use
	localparam int                CFG_W     = 4;
	localparam logic [CFG_W-1:0]  CFG_RESET = 4'd3;

	// Fault counter width
	localparam int FAULT_W = 32;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} lrupr_state_t;

	// Control part of the search token walking the cell chain
	typedef struct packed {
		logic valid;   // token present in this stage
		logic hit;     // a matching frame was seen upstream
		logic found;   // an eviction candidate was seen upstream
	} lrupr_scan_t;

	// Update broadcast from the controller to every cell
	typedef struct packed {
		logic clear;       // empty every frame
		logic touch;       // make upd_slot most recent, age the others
		logic fresh;       // slot had no previous rank (new fill)
		logic write_page;  // load the request page into upd_slot
		logic set_valid;   // mark upd_slot occupied
	} lrupr_upd_t;

endpackage

/* sv/lrupr_cell.sv */
// One frame of the LRU frame store: page, valid bit, recency rank and one
// stage of the search token chain. Depends on lrupr_pkg.
module lrupr_cell #(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 16,
	parameter int IDX       = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [$clog2(FRAMES+1)-1:0] n_act,
	input  logic [PAGE_BITS-1:0]        req_page,
	// update broadcast
	input  lrupr_pkg::lrupr_upd_t       upd,
	input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] upd_slot,
	input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] upd_old_rank,
	// token from the previous cell
	input  lrupr_pkg::lrupr_scan_t      tin,
	input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] tin_hit_idx,
	input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] tin_hit_rank,
	input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] tin_best_idx,
	input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] tin_best_rank,
	input  logic [PAGE_BITS-1:0]        tin_best_page,
	// token to the next cell
	output lrupr_pkg::lrupr_scan_t      tout,
	output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] tout_hit_idx,
	output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] tout_hit_rank,
	output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] tout_best_idx,
	output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] tout_best_rank,
	output logic [PAGE_BITS-1:0]        tout_best_page
);

	localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int RANK_W = IDX_W;
	localparam int CNT_W  = $clog2(FRAMES + 1);

	localparam logic [CNT_W-1:0]  POS      = CNT_W'(IDX);
	localparam logic [IDX_W-1:0]  MY_IDX   = IDX_W'(IDX);
	localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(FRAMES - 1);

	// Frame state
	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q;
	logic [RANK_W-1:0]    rank_q;

	// Token stage registers
	lrupr_pkg::lrupr_scan_t tok_q;
	logic [IDX_W-1:0]       hit_idx_q;
	logic [RANK_W-1:0]      hit_rank_q;
	logic [IDX_W-1:0]       best_idx_q;
	logic [RANK_W-1:0]      best_rank_q;
	logic [PAGE_BITS-1:0]   best_page_q;

	lrupr_pkg::lrupr_scan_t tok_d;
	logic [IDX_W-1:0]       hit_idx_d;
	logic [RANK_W-1:0]      hit_rank_d;
	logic [IDX_W-1:0]       best_idx_d;
	logic [RANK_W-1:0]      best_rank_d;
	logic [PAGE_BITS-1:0]   best_page_d;

	logic live;
	logic is_slot;

	// Frames beyond the configured limit are invisible to the search
	assign live    = valid_q && (POS < n_act);
	assign is_slot = (upd_slot == MY_IDX);

	// Search step: first hit wins, oldest rank wins with lowest index on ties
	always_comb begin
		tok_d       = tin;
		hit_idx_d   = tin_hit_idx;
		hit_rank_d  = tin_hit_rank;
		best_idx_d  = tin_best_idx;
		best_rank_d = tin_best_rank;
		best_page_d = tin_best_page;
		if (live && !tin.hit && (page_q == req_page)) begin
			tok_d.hit  = 1'b1;
			hit_idx_d  = MY_IDX;
			hit_rank_d = rank_q;
		end
		if (live && (!tin.found || (rank_q > tin_best_rank))) begin
			tok_d.found = 1'b1;
			best_idx_d  = MY_IDX;
			best_rank_d = rank_q;
			best_page_d = page_q;
		end
	end

	// Token stage: control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	// Token stage: data
	always_ff @(posedge clk) begin
		hit_idx_q   <= hit_idx_d;
		hit_rank_q  <= hit_rank_d;
		best_idx_q  <= best_idx_d;
		best_rank_q <= best_rank_d;
		best_page_q <= best_page_d;
	end

	// Valid bit and recency rank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (upd.clear) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (upd.touch) begin
			if (is_slot) begin
				rank_q <= '0;
				if (upd.set_valid) begin
					valid_q <= 1'b1;
				end
			end else if (valid_q && (upd.fresh || (rank_q < upd_old_rank)) &&
			             (rank_q != RANK_MAX)) begin
				rank_q <= rank_q + RANK_W'(1);
			end
		end
	end

	// Page tag
	always_ff @(posedge clk) begin
		if (upd.touch && upd.write_page && is_slot) begin
			page_q <= req_page;
		end
	end

	assign tout           = tok_q;
	assign tout_hit_idx   = hit_idx_q;
	assign tout_hit_rank  = hit_rank_q;
	assign tout_best_idx  = best_idx_q;
	assign tout_best_rank = best_rank_q;
	assign tout_best_page = best_page_q;

endmodule

/* sv/lru_page_replacement.sv */
// Fully associative LRU frame store: for a page access a search token walks
// the row of frame cells one cell per cycle, then the recency update is
// committed and the result register is loaded once it is free; only then
// can the next request be accepted. A clear request also ends with a result
// load. The result register holds a finished result until it is taken while
// the next request is already accepted. frames_in_use is written through
// cfg_we/cfg_wdata, 0 acts as 1 and values above FRAMES act as FRAMES;
// write it only while the block is idle.
// Depends on lrupr_pkg and lrupr_cell.
module lru_page_replacement #(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 16
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	// configuration
	input  logic                                          cfg_we,
	input  logic [lrupr_pkg::CFG_W-1:0]                   cfg_wdata,
	// request channel
	input  logic                                          in_valid,
	output logic                                          in_ready,
	input  logic                                          cmd,
	input  logic [PAGE_BITS-1:0]                          page_number,
	// result channel
	output logic                                          out_valid,
	input  logic                                          out_ready,
	output logic                                          page_fault,
	output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] slot,
	output logic                                          evicted_valid,
	output logic [PAGE_BITS-1:0]                          evicted_page,
	output logic [lrupr_pkg::FAULT_W-1:0]                 fault_total
);

	localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int RANK_W  = IDX_W;
	localparam int CNT_W   = $clog2(FRAMES + 1);
	localparam int FAULT_W = lrupr_pkg::FAULT_W;

	// Configuration register
	logic [lrupr_pkg::CFG_W-1:0] cfg_q;
	logic [CNT_W-1:0]            n_act;

	// Controller state
	lrupr_pkg::lrupr_state_t state_q, state_d;
	logic                    start_q;
	logic [PAGE_BITS-1:0]    page_q;
	logic [CNT_W-1:0]        filled_q;
	logic [FAULT_W-1:0]      fault_q;

	// Pending result, waiting for the output register
	logic                 res_fault_q;
	logic [IDX_W-1:0]     res_slot_q;
	logic                 res_evict_q;
	logic [PAGE_BITS-1:0] res_evp_q;
	logic [FAULT_W-1:0]   res_total_q;

	// Output register
	logic                 out_valid_q;
	logic                 out_fault_q;
	logic [IDX_W-1:0]     out_slot_q;
	logic                 out_evict_q;
	logic [PAGE_BITS-1:0] out_evp_q;
	logic [FAULT_W-1:0]   out_total_q;

	// Token chain wiring
	lrupr_pkg::lrupr_scan_t tok       [FRAMES+1];
	logic [IDX_W-1:0]       hit_idx   [FRAMES+1];
	logic [RANK_W-1:0]      hit_rank  [FRAMES+1];
	logic [IDX_W-1:0]       best_idx  [FRAMES+1];
	logic [RANK_W-1:0]      best_rank [FRAMES+1];
	logic [PAGE_BITS-1:0]   best_page [FRAMES+1];

	// Control outputs
	logic                  accept;
	logic                  load_out;
	logic                  commit;
	lrupr_pkg::lrupr_upd_t upd;

	// Decision from the finished search
	logic                 have_room;
	logic                 miss;
	logic                 evict;
	logic [IDX_W-1:0]     dec_slot;
	logic [RANK_W-1:0]    dec_old_rank;
	logic                 dec_fresh;
	logic                 dec_fill;
	logic [FAULT_W-1:0]   fault_nxt;

	// Configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= lrupr_pkg::CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// Clamp frames in use to 1..FRAMES
	always_comb begin
		if (cfg_q == '0) begin
			n_act = CNT_W'(1);
		end else if (32'(cfg_q) > 32'(FRAMES)) begin
			n_act = CNT_W'(FRAMES);
		end else begin
			n_act = CNT_W'(cfg_q);
		end
	end

	// Search token entry
	assign tok[0]       = '{valid: start_q, hit: 1'b0, found: 1'b0};
	assign hit_idx[0]   = '0;
	assign hit_rank[0]  = '0;
	assign best_idx[0]  = '0;
	assign best_rank[0] = '0;
	assign best_page[0] = '0;

	// Row of frame cells
	for (genvar g = 0; g < FRAMES; g++) begin : g_cell
		lrupr_cell #(
			.FRAMES    (FRAMES),
			.PAGE_BITS (PAGE_BITS),
			.IDX       (g)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.n_act          (n_act),
			.req_page       (page_q),
			.upd            (upd),
			.upd_slot       (dec_slot),
			.upd_old_rank   (dec_old_rank),
			.tin            (tok[g]),
			.tin_hit_idx    (hit_idx[g]),
			.tin_hit_rank   (hit_rank[g]),
			.tin_best_idx   (best_idx[g]),
			.tin_best_rank  (best_rank[g]),
			.tin_best_page  (best_page[g]),
			.tout           (tok[g+1]),
			.tout_hit_idx   (hit_idx[g+1]),
			.tout_hit_rank  (hit_rank[g+1]),
			.tout_best_idx  (best_idx[g+1]),
			.tout_best_rank (best_rank[g+1]),
			.tout_best_page (best_page[g+1])
		);
	end

	// Replacement decision once the token leaves the last cell
	always_comb begin
		have_room    = (filled_q < n_act);
		miss         = !tok[FRAMES].hit;
		evict        = 1'b0;
		dec_slot     = '0;
		dec_old_rank = '0;
		dec_fresh    = 1'b0;
		dec_fill     = 1'b0;
		if (!miss) begin
			dec_slot     = hit_idx[FRAMES];
			dec_old_rank = hit_rank[FRAMES];
		end else if (have_room) begin
			dec_slot  = IDX_W'(filled_q);
			dec_fresh = 1'b1;
			dec_fill  = 1'b1;
		end else if (tok[FRAMES].found) begin
			dec_slot     = best_idx[FRAMES];
			dec_old_rank = best_rank[FRAMES];
			evict        = 1'b1;
		end else begin
			dec_fresh = 1'b1;
		end
		fault_nxt = fault_q;
		if (miss && (fault_q != '1)) begin
			fault_nxt = fault_q + FAULT_W'(1);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lrupr_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = cmd ? lrupr_pkg::ST_EMIT : lrupr_pkg::ST_SCAN;
				end
			end
			lrupr_pkg::ST_SCAN: begin
				if (tok[FRAMES].valid) begin
					state_d = lrupr_pkg::ST_EMIT;
				end
			end
			lrupr_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					state_d = lrupr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lrupr_pkg::ST_IDLE;
			end
		endcase
	end

	// Controller outputs
	always_comb begin
		in_ready       = 1'b0;
		load_out       = 1'b0;
		commit         = 1'b0;
		case (state_q)
			lrupr_pkg::ST_IDLE: in_ready = 1'b1;
			lrupr_pkg::ST_SCAN: commit   = tok[FRAMES].valid;
			lrupr_pkg::ST_EMIT: load_out = !out_valid_q || out_ready;
			default:            in_ready = 1'b0;
		endcase
		accept         = in_valid && in_ready;
		upd.clear      = accept && cmd;
		upd.touch      = commit;
		upd.fresh      = dec_fresh;
		upd.write_page = miss;
		upd.set_valid  = miss && !evict;
	end

	// Controller registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lrupr_pkg::ST_IDLE;
			start_q  <= 1'b0;
			filled_q <= '0;
			fault_q  <= '0;
		end else begin
			state_q <= state_d;
			start_q <= accept && !cmd;
			if (upd.clear) begin
				filled_q <= '0;
				fault_q  <= '0;
			end else if (commit) begin
				fault_q <= fault_nxt;
				if (dec_fill) begin
					filled_q <= filled_q + CNT_W'(1);
				end
			end
		end
	end

	// Request page and pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			page_q <= page_number;
		end
		if (upd.clear) begin
			res_fault_q <= 1'b0;
			res_slot_q  <= '0;
			res_evict_q <= 1'b0;
			res_evp_q   <= '0;
			res_total_q <= '0;
		end else if (commit) begin
			res_fault_q <= miss;
			res_slot_q  <= dec_slot;
			res_evict_q <= evict;
			res_evp_q   <= evict ? best_page[FRAMES] : '0;
			res_total_q <= fault_nxt;
		end
	end

	// Output register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register: payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_fault_q <= res_fault_q;
			out_slot_q  <= res_slot_q;
			out_evict_q <= res_evict_q;
			out_evp_q   <= res_evp_q;
			out_total_q <= res_total_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign page_fault    = out_fault_q;
	assign slot          = out_slot_q;
	assign evicted_valid = out_evict_q;
	assign evicted_page  = out_evp_q;
	assign fault_total   = out_total_q;

`ifndef SYNTHESIS
	// Fill count never passes the number of frames
	a_filled_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(filled_q) <= 32'(FRAMES))
		else $error("fill count beyond frame count");

	// A search token that enters the chain always leaves the last cell
	a_token_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> ##FRAMES tok[FRAMES].valid)
		else $error("search token lost in cell chain");

	// Fault count only falls on a clear
	a_fault_mono: assert property (@(posedge clk) disable iff (!arst_n)
		!upd.clear |=> (fault_q >= $past(fault_q)))
		else $error("fault count decreased without clear");

	// A fill into an empty frame advances the fill count by one
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && dec_fill) |=> (filled_q == $past(filled_q) + CNT_W'(1)))
		else $error("fill count not advanced on fill");

	// A result ready to leave reaches the output register
	a_emit_load: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q)
		else $error("result not loaded into output register");
`endif

endmodule
